// ===== src/oal_pkg.sv =====
// Package of shared types and codes for the ordered array list engine.
package oal_pkg;

    typedef enum logic [1:0] {
        FN_READ   = 2'd0,
        FN_LOCATE = 2'd1,
        FN_INSERT = 2'd2,
        FN_DELETE = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_SCAN,
        S_SHIFT,
        S_PUT
    } t_state;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned POS_W  = 8;

endpackage

// ===== src/oal_ifs.sv =====
// Request and response channel interfaces of the ordered array list engine.
interface oal_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [7:0]         position;
    logic signed [31:0] value;

    modport source (output valid, output func, output position, output value, input ready);
    modport sink   (input valid, input func, input position, input value, output ready);
endinterface

interface oal_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [7:0]         found_position;
    logic [7:0]         current_length;

    modport source (output valid, output status, output read_value, output found_position,
                    output current_length, input ready);
    modport sink   (input valid, input status, input read_value, input found_position,
                    input current_length, output ready);
endinterface

// ===== src/oal_store.sv =====
// Entry store: one write port and one read port with registered read data.
module oal_store
    import oal_pkg::*;
#(
    parameter int unsigned DEPTH = 128,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/oal_ctrl.sv =====
// Sequencer that walks the entry store for each request and holds the response register.
module oal_ctrl
    import oal_pkg::*;
#(
    parameter int unsigned DEPTH = 128,
    localparam int unsigned AW   = $clog2(DEPTH),
    localparam int unsigned CW   = $clog2(DEPTH + 1),
    localparam int unsigned XW   = ((CW > POS_W) ? CW : POS_W) + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    oal_req_if.sink           i_req,
    oal_rsp_if.source         o_rsp,
    output logic              o_rd_en,
    output logic [AW-1:0]     o_rd_addr,
    output logic              o_wr_en,
    output logic [AW-1:0]     o_wr_addr,
    output logic [DATA_W-1:0] o_wr_data,
    input  logic [DATA_W-1:0] i_rd_data
);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    t_func             r_func, n_func;
    logic [DATA_W-1:0] r_val, n_val;
    logic [AW-1:0]     r_ptr, n_ptr;
    logic [AW-1:0]     r_tgt, n_tgt;
    logic              r_out_vld, n_out_vld;
    t_status           r_status, n_status;
    logic [DATA_W-1:0] r_rdval, n_rdval;
    logic [POS_W-1:0]  r_found, n_found;
    logic [POS_W-1:0]  r_len, n_len;

    logic              w_ready;
    logic              w_acc;
    t_func             w_fn;
    logic [XW-1:0]     w_pos_x;
    logic [XW-1:0]     w_cnt_x;
    logic [XW-1:0]     w_ncnt_x;
    logic [XW-1:0]     w_ptr_p1_x;
    logic              w_rd_ok;
    logic              w_ins_ok;
    logic              w_full;
    logic              w_ins_end;
    logic              w_del_end;
    logic              w_cnt_nz;
    logic              w_last;
    logic              w_hit;
    logic              w_load;
    logic [AW-1:0]     w_pos_m1;
    logic [AW-1:0]     w_cnt_m1;
    logic [AW-1:0]     w_pos_a;

    assign w_ready    = (r_state == S_IDLE) && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = w_ready;
    assign w_acc      = i_req.valid && w_ready;
    assign w_fn       = t_func'(i_req.func);
    assign w_pos_x    = XW'(i_req.position);
    assign w_cnt_x    = XW'(r_count);
    assign w_ncnt_x   = XW'(n_count);
    assign w_ptr_p1_x = XW'(r_ptr) + XW'(1);
    assign w_rd_ok    = (w_pos_x != '0) && (w_pos_x <= w_cnt_x);
    assign w_ins_ok   = (w_pos_x != '0) && (w_pos_x <= w_cnt_x + XW'(1));
    assign w_full     = (w_cnt_x == XW'(DEPTH));
    assign w_ins_end  = (w_pos_x == w_cnt_x + XW'(1));
    assign w_del_end  = (w_pos_x == w_cnt_x);
    assign w_cnt_nz   = (r_count != '0);
    assign w_pos_m1   = AW'(w_pos_x - XW'(1));
    assign w_cnt_m1   = AW'(w_cnt_x - XW'(1));
    assign w_pos_a    = AW'(w_pos_x);
    assign w_last     = (r_ptr == r_tgt);
    assign w_hit      = (i_rd_data == r_val);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (w_fn)
                        FN_READ:   n_state = w_rd_ok ? S_RD : S_IDLE;
                        FN_LOCATE: n_state = w_cnt_nz ? S_SCAN : S_IDLE;
                        FN_INSERT: begin
                            if (w_ins_ok && !w_full) begin
                                n_state = w_ins_end ? S_PUT : S_SHIFT;
                            end
                        end
                        FN_DELETE: n_state = (w_rd_ok && !w_del_end) ? S_SHIFT : S_IDLE;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_RD:    n_state = S_IDLE;
            S_SCAN:  n_state = (w_hit || w_last) ? S_IDLE : S_SCAN;
            S_SHIFT: begin
                if (w_last) begin
                    n_state = (r_func == FN_INSERT) ? S_PUT : S_IDLE;
                end
            end
            S_PUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Store accesses.
    always_comb begin
        o_rd_en   = 1'b0;
        o_rd_addr = '0;
        o_wr_en   = 1'b0;
        o_wr_addr = '0;
        o_wr_data = i_rd_data;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (w_fn)
                        FN_READ: begin
                            o_rd_en   = w_rd_ok;
                            o_rd_addr = w_pos_m1;
                        end
                        FN_LOCATE: begin
                            o_rd_en   = w_cnt_nz;
                            o_rd_addr = '0;
                        end
                        FN_INSERT: begin
                            o_rd_en   = w_ins_ok && !w_full && !w_ins_end;
                            o_rd_addr = w_cnt_m1;
                        end
                        FN_DELETE: begin
                            o_rd_en   = w_rd_ok && !w_del_end;
                            o_rd_addr = w_pos_a;
                        end
                        default: o_rd_en = 1'b0;
                    endcase
                end
            end
            S_SCAN: begin
                o_rd_en   = !w_hit && !w_last;
                o_rd_addr = r_ptr + AW'(1);
            end
            S_SHIFT: begin
                o_wr_en = 1'b1;
                o_rd_en = !w_last;
                if (r_func == FN_INSERT) begin
                    o_wr_addr = r_ptr + AW'(1);
                    o_rd_addr = r_ptr - AW'(1);
                end else begin
                    o_wr_addr = r_ptr - AW'(1);
                    o_rd_addr = r_ptr + AW'(1);
                end
            end
            S_PUT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_tgt;
                o_wr_data = r_val;
            end
            default: o_rd_en = 1'b0;
        endcase
    end

    // Datapath and response register.
    always_comb begin
        n_count  = r_count;
        n_func   = r_func;
        n_val    = r_val;
        n_ptr    = r_ptr;
        n_tgt    = r_tgt;
        n_status = r_status;
        n_rdval  = r_rdval;
        n_found  = r_found;
        w_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_func   = w_fn;
                    n_val    = i_req.value;
                    n_rdval  = '0;
                    n_found  = '0;
                    n_status = ST_OK;
                    case (w_fn)
                        FN_READ: begin
                            if (!w_rd_ok) begin
                                n_status = ST_RANGE;
                            end
                            w_load = !w_rd_ok;
                        end
                        FN_LOCATE: begin
                            n_ptr    = '0;
                            n_tgt    = w_cnt_m1;
                            n_status = ST_NOTFOUND;
                            w_load   = !w_cnt_nz;
                        end
                        FN_INSERT: begin
                            n_ptr = w_cnt_m1;
                            n_tgt = w_pos_m1;
                            if (!w_ins_ok) begin
                                n_status = ST_RANGE;
                                w_load   = 1'b1;
                            end else if (w_full) begin
                                n_status = ST_FULL;
                                w_load   = 1'b1;
                            end
                        end
                        FN_DELETE: begin
                            n_ptr = w_pos_a;
                            n_tgt = w_cnt_m1;
                            if (!w_rd_ok) begin
                                n_status = ST_RANGE;
                                w_load   = 1'b1;
                            end else if (w_del_end) begin
                                n_count = r_count - CW'(1);
                                w_load  = 1'b1;
                            end
                        end
                        default: w_load = 1'b0;
                    endcase
                end
            end
            S_RD: begin
                n_rdval = i_rd_data;
                w_load  = 1'b1;
            end
            S_SCAN: begin
                n_ptr = r_ptr + AW'(1);
                if (w_hit) begin
                    n_status = ST_OK;
                    n_found  = w_ptr_p1_x[POS_W-1:0];
                    w_load   = 1'b1;
                end else if (w_last) begin
                    w_load = 1'b1;
                end
            end
            S_SHIFT: begin
                if (r_func == FN_INSERT) begin
                    n_ptr = r_ptr - AW'(1);
                end else begin
                    n_ptr = r_ptr + AW'(1);
                    if (w_last) begin
                        n_count = r_count - CW'(1);
                        w_load  = 1'b1;
                    end
                end
            end
            S_PUT: begin
                n_count = r_count + CW'(1);
                w_load  = 1'b1;
            end
            default: w_load = 1'b0;
        endcase
        n_len     = w_load ? w_ncnt_x[POS_W-1:0] : r_len;
        n_out_vld = w_load ? 1'b1 : (r_out_vld && !o_rsp.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_val    <= n_val;
        r_ptr    <= n_ptr;
        r_tgt    <= n_tgt;
        r_status <= n_status;
        r_rdval  <= n_rdval;
        r_found  <= n_found;
        r_len    <= n_len;
    end

    assign o_rsp.valid          = r_out_vld;
    assign o_rsp.status         = r_status;
    assign o_rsp.read_value     = r_rdval;
    assign o_rsp.found_position = r_found;
    assign o_rsp.current_length = r_len;

endmodule

// ===== src/ordered_array_list_engine.sv =====
// Top level of the ordered array list engine: sequencer and entry store.
// Read fetches the entry at the transfer and loads the response in S_RD; an error, a locate on an
// empty list or a delete of the last entry loads the response at the transfer. Locate compares the
// entries in order, one store read per cycle, until a match or the last one. Insert and delete move
// one entry per cycle through the store's single read and write ports; insert ends in S_PUT.
// One request is handled at a time; reset clears only the state, the length and the response valid flag.
module ordered_array_list_engine
    import oal_pkg::*;
#(
    parameter int unsigned DEPTH = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    oal_req_if.sink   i_req,
    oal_rsp_if.source o_rsp
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic              w_rd_en;
    logic [AW-1:0]     w_rd_addr;
    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    logic [DATA_W-1:0] w_wr_data;
    logic [DATA_W-1:0] w_rd_data;

    oal_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .i_rd_data (w_rd_data)
    );

    oal_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data)
    );

endmodule

// ===== src/oal_checker.sv =====
// Port-level checker for the ordered array list engine and its bind statement.
module oal_checker
    import oal_pkg::*;
#(
    parameter int unsigned DEPTH = 128
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [1:0]  i_rsp_status,
    input logic [31:0] i_rsp_read_value,
    input logic [7:0]  i_rsp_found_position,
    input logic [7:0]  i_rsp_current_length
);

    localparam logic [7:0] DEPTH_LO = 8'(DEPTH);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status)
            && $stable(i_rsp_read_value) && $stable(i_rsp_current_length))
        else $error("Stalled response changed.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("Response valid straight after reset.");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |-> !(i_rsp_valid && !i_rsp_ready))
        else $error("Request transfer while a response is stalled.");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status == ST_FULL) |-> i_rsp_current_length == DEPTH_LO)
        else $error("Full status with a length below the depth.");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_found_position != 8'd0) |-> i_rsp_status == ST_OK)
        else $error("Found position reported without ok status.");

endmodule

bind ordered_array_list_engine oal_checker #(
    .DEPTH (DEPTH)
) u_oal_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_req_valid          (i_req.valid),
    .i_req_ready          (i_req.ready),
    .i_rsp_valid          (o_rsp.valid),
    .i_rsp_ready          (o_rsp.ready),
    .i_rsp_status         (o_rsp.status),
    .i_rsp_read_value     (o_rsp.read_value),
    .i_rsp_found_position (o_rsp.found_position),
    .i_rsp_current_length (o_rsp.current_length)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the ordered array list engine with a driver, a monitor and a predictor.
module tb_top;
    import oal_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LIST_DEPTH    = 128;
    localparam int unsigned PHASE_ITEMS   = 275;
    localparam int unsigned HOLD_AT       = 60;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        t_func              func;
        logic [7:0]         position;
        logic signed [31:0] value;
    } t_list_req;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] read_value;
        logic [7:0]         found_position;
        logic [7:0]         current_length;
    } t_list_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    oal_req_if req_if ();
    oal_rsp_if rsp_if ();

    ordered_array_list_engine #(
        .DEPTH (LIST_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_list_req          pending_requests[$];
    t_list_result       expected_results[$];
    logic signed [31:0] list_mem[LIST_DEPTH];
    int unsigned        list_len = 0;
    int unsigned        plan_len = 0;
    bit                 growing = 1'b1;
    int unsigned        sender_idle = 0;
    int unsigned        receiver_stall = 0;
    int unsigned        requests_taken;
    int unsigned        hold_left;
    bit                 hold_done;
    int unsigned        quiet_cycles;
    int unsigned        error_count = 0;

    always #6 i_clk = ~i_clk;

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("ERROR at %0t ns: %s got 0x%0h, expected 0x%0h", $time, field, got, want);
        error_count++;
    endtask

    function automatic t_list_result apply_request(t_list_req r);
        t_list_result res;
        int unsigned  p;
        int unsigned  i;
        bit           hit;
        res = '0;
        res.status = ST_OK;
        p = 32'(r.position);
        hit = 1'b0;
        case (r.func)
            FN_READ: begin
                if (p >= 1 && p <= list_len) begin
                    res.read_value = list_mem[p - 1];
                end else begin
                    res.status = ST_RANGE;
                end
            end
            FN_LOCATE: begin
                res.status = ST_NOTFOUND;
                for (i = 0; i < list_len; i++) begin
                    if (!hit && list_mem[i] == r.value) begin
                        hit = 1'b1;
                        res.found_position = 8'(i + 1);
                        res.status = ST_OK;
                    end
                end
            end
            FN_INSERT: begin
                if (p < 1 || p > list_len + 1) begin
                    res.status = ST_RANGE;
                end else if (list_len >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (i = list_len; i >= p; i--) begin
                        list_mem[i] = list_mem[i - 1];
                    end
                    list_mem[p - 1] = r.value;
                    list_len++;
                end
            end
            default: begin
                if (p >= 1 && p <= list_len) begin
                    for (i = p; i < list_len; i++) begin
                        list_mem[i - 1] = list_mem[i];
                    end
                    list_len--;
                end else begin
                    res.status = ST_RANGE;
                end
            end
        endcase
        res.current_length = 8'(list_len);
        return res;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            4:       return 32'h5555_5555;
            5:       return 32'haaaa_aaaa;
            6:       return 32'h0000_0001;
            7:       return 32'h0000_002a;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_request(t_func f, logic [7:0] p, logic [31:0] v);
        t_list_req r;
        r.func = f;
        r.position = p;
        r.value = v;
        if (f == FN_INSERT && p >= 1 && p <= plan_len + 1 && plan_len < LIST_DEPTH) begin
            plan_len++;
        end else if (f == FN_DELETE && p >= 1 && p <= plan_len) begin
            plan_len--;
        end
        pending_requests.push_back(r);
    endtask

    task automatic queue_random(int unsigned count);
        t_func       f;
        logic [7:0]  p;
        int unsigned roll;
        int unsigned hi;
        repeat (count) begin
            if (plan_len == LIST_DEPTH && $urandom_range(3) == 0) begin
                growing = 1'b0;
            end else if (plan_len == 0 && $urandom_range(3) == 0) begin
                growing = 1'b1;
            end else if ($urandom_range(149) == 0) begin
                growing = !growing;
            end
            roll = $urandom_range(99);
            if (roll < 55) begin
                f = growing ? FN_INSERT : FN_DELETE;
            end else if (roll < 65) begin
                f = growing ? FN_DELETE : FN_INSERT;
            end else if (roll < 85) begin
                f = FN_READ;
            end else begin
                f = FN_LOCATE;
            end
            hi = (f == FN_INSERT) ? plan_len + 1 : plan_len;
            roll = $urandom_range(99);
            if (roll < 10 || hi == 0) begin
                p = 8'($urandom_range(255));
            end else if (roll < 20) begin
                p = 8'd1;
            end else if (roll < 30) begin
                p = 8'(hi);
            end else begin
                p = 8'($urandom_range(hi, 1));
            end
            add_request(f, p, pick_value());
        end
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || req_if.valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin : drive
        t_list_req nxt;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_if.ready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle) begin
                nxt = pending_requests.pop_front();
                req_if.valid    <= 1'b1;
                req_if.func     <= nxt.func;
                req_if.position <= nxt.position;
                req_if.value    <= nxt.value;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : observe
        t_list_result want;
        t_list_req    taken;
        if (!i_rst_n) begin
            rsp_if.ready   <= 1'b0;
            requests_taken <= 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("response with none expected, status",
                                    32'(rsp_if.status), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (rsp_if.status !== want.status) begin
                        report_mismatch("status", 32'(rsp_if.status), 32'(want.status));
                    end
                    if (rsp_if.read_value !== want.read_value) begin
                        report_mismatch("read_value", rsp_if.read_value, want.read_value);
                    end
                    if (rsp_if.found_position !== want.found_position) begin
                        report_mismatch("found_position", 32'(rsp_if.found_position),
                                        32'(want.found_position));
                    end
                    if (rsp_if.current_length !== want.current_length) begin
                        report_mismatch("current_length", 32'(rsp_if.current_length),
                                        32'(want.current_length));
                    end
                end
            end
            if (req_if.valid && req_if.ready) begin
                taken.func     = t_func'(req_if.func);
                taken.position = req_if.position;
                taken.value    = req_if.value;
                expected_results.push_back(apply_request(taken));
                requests_taken <= requests_taken + 1;
            end
            rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_stall);
        end
    end

    // The receiver holds off once for a long stretch after HOLD_AT requests have been taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && requests_taken >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR at %0t ns: no transfer for %0d cycles", $time, quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.func     = FN_READ;
        req_if.position = '0;
        req_if.value    = '0;
        rsp_if.ready    = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_request(FN_READ,   8'd1,   32'h1234_5678);
        add_request(FN_DELETE, 8'd1,   32'h0);
        add_request(FN_LOCATE, 8'd0,   32'h0);
        add_request(FN_INSERT, 8'd0,   32'h1);
        add_request(FN_INSERT, 8'd2,   32'h2);
        add_request(FN_INSERT, 8'd1,   32'h8000_0000);
        add_request(FN_INSERT, 8'd2,   32'h7fff_ffff);
        add_request(FN_INSERT, 8'd1,   32'hffff_ffff);
        add_request(FN_INSERT, 8'd2,   32'h5555_5555);
        add_request(FN_INSERT, 8'd255, 32'h0);
        add_request(FN_READ,   8'd1,   32'hffff_ffff);
        add_request(FN_READ,   8'd4,   32'h0);
        add_request(FN_READ,   8'd5,   32'h0);
        add_request(FN_READ,   8'd0,   32'h0);
        add_request(FN_READ,   8'd255, 32'h0);
        add_request(FN_LOCATE, 8'd255, 32'h7fff_ffff);
        add_request(FN_LOCATE, 8'd3,   32'haaaa_aaaa);
        add_request(FN_INSERT, 8'd5,   32'hffff_ffff);
        add_request(FN_LOCATE, 8'd0,   32'hffff_ffff);
        add_request(FN_DELETE, 8'd5,   32'h0);
        add_request(FN_DELETE, 8'd1,   32'hffff_ffff);
        add_request(FN_DELETE, 8'd2,   32'h0);
        add_request(FN_DELETE, 8'd0,   32'h0);
        add_request(FN_DELETE, 8'd3,   32'h0);
        add_request(FN_READ,   8'd2,   32'h0);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin sender_idle = 0;  receiver_stall = 0;  end
                1:       begin sender_idle = 80; receiver_stall = 0;  end
                2:       begin sender_idle = 0;  receiver_stall = 80; end
                default: begin sender_idle = 8;  receiver_stall = 8;  end
            endcase
            queue_random(PHASE_ITEMS);
            wait_drained();
        end

        repeat (LIST_DEPTH + 20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
